@@ sv/rsns_pkg.sv @@
// shared types, constants and scale tables for the random scale note sequencer
`default_nettype none

package rsns_pkg;

  // default sizing of the sequencer
  localparam int unsigned SEQ_DEPTH_DEF      = 16;
  localparam int unsigned TICKS_PER_STEP_DEF = 6;

  // divider geometry: 32-bit dividend, 9-bit divisor, four quotient bits a cycle
  localparam int unsigned DVD_W     = 32;
  localparam int unsigned DSR_W     = 9;
  localparam int unsigned DIV_CHUNK = 4;
  localparam int unsigned STEP_W    = 4;

  // pitch constants
  localparam logic [7:0]  NO_NOTE   = 8'd255;
  localparam logic [6:0]  PITCH_MAX = 7'd127;
  localparam logic [8:0]  OCT_BIAS  = 9'd24;
  localparam logic [8:0]  OCTAVE    = 9'd12;

  // configuration register indexes
  localparam logic [2:0] CFG_LOW_NOTE     = 3'd0;
  localparam logic [2:0] CFG_HIGH_NOTE    = 3'd1;
  localparam logic [2:0] CFG_TONIC        = 3'd2;
  localparam logic [2:0] CFG_SCALE_SELECT = 3'd3;
  localparam logic [2:0] CFG_SEQ_LENGTH   = 3'd4;
  localparam logic [2:0] CFG_FROZEN       = 3'd5;
  localparam logic [2:0] CFG_GATE_LENGTH  = 3'd6;
  localparam logic [2:0] CFG_MIDI_CHANNEL = 3'd7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // scale degrees in semitones, unused slots zero
  localparam logic [3:0] SCALE_DEG [4][12] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
  };
  localparam logic [3:0] SCALE_SIZE [4] = '{4'd12, 4'd7, 4'd5, 4'd7};

  // input item
  typedef struct packed {
    logic [31:0] tick_count;
    logic [15:0] random_word;
  } in_item_t;

  // result item
  typedef struct packed {
    logic       is_start;
    logic [6:0] pitch;
    logic [4:0] channel_out;
  } out_item_t;

  // divider request, dividend left-aligned, steps counts four-bit chunks
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  // divider response
  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

  // degree of a scale at a rank inside the octave
  function automatic logic [3:0] scale_deg(input logic [1:0] sc, input logic [3:0] idx);
    logic [3:0] deg;
    deg = 4'd0;
    if (idx < 4'd12) begin
      deg = SCALE_DEG[sc][idx];
    end
    return deg;
  endfunction

  // count of scale degrees strictly below a semitone within the octave
  function automatic logic [3:0] below_cnt(input logic [1:0] sc, input logic [3:0] r);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if ((4'(i) < SCALE_SIZE[sc]) && (SCALE_DEG[sc][i] < r)) begin
        cnt = cnt + 4'd1;
      end
    end
    return cnt;
  endfunction

  // output pitch saturation
  function automatic logic [6:0] sat_pitch(input logic [7:0] p);
    return p[7] ? PITCH_MAX : p[6:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/rsns_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none

module rsns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/rsns_div.sv @@
// shared restoring divider, four quotient bits per cycle
`default_nettype none

module rsns_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rsns_pkg::div_req_t req_i,
  output rsns_pkg::div_rsp_t     rsp_o
);

  localparam int unsigned DvdW = rsns_pkg::DVD_W;
  localparam int unsigned DsrW = rsns_pkg::DSR_W;
  localparam int unsigned StW  = rsns_pkg::STEP_W;

  logic [DvdW-1:0] quo_q, quo_d;
  logic [DsrW:0]   rem_q, rem_d;
  logic [DsrW-1:0] dsr_q;
  logic [StW-1:0]  cnt_q, cnt_d;
  logic            done_q, done_d;

  // one chunk of shift, compare and subtract
  always_comb begin
    logic [DvdW-1:0] q;
    logic [DsrW:0]   r;
    q      = quo_q;
    r      = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      q     = req_i.dividend;
      r     = '0;
      cnt_d = req_i.steps;
    end else if (cnt_q != '0) begin
      for (int i = 0; i < int'(rsns_pkg::DIV_CHUNK); i++) begin
        r = {r[DsrW-1:0], q[DvdW-1]};
        q = {q[DvdW-2:0], 1'b0};
        if (r >= {1'b0, dsr_q}) begin
          r    = r - {1'b0, dsr_q};
          q[0] = 1'b1;
        end
      end
      cnt_d  = cnt_q - StW'(1);
      done_d = (cnt_q == StW'(1));
    end
    quo_d = q;
    rem_d = r;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      dsr_q <= req_i.divisor;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q[DsrW-1:0];

endmodule

`default_nettype wire

@@ sv/random_scale_note_sequencer_unit.sv @@
// Random scale note sequencer: one tick item in, zero or one note event out.
// A tick off the step grid makes one pass through the shared divider, a frozen
// replay two and a fresh draw up to six; one item at a time, input stalled
// until it is done.
// Reset (async, active low) loads the register defaults, clears every step
// valid bit so stored notes read as zero, and marks no note sounding.
`default_nettype none

module random_scale_note_sequencer_unit #(
  parameter int unsigned SEQ_DEPTH      = rsns_pkg::SEQ_DEPTH_DEF,
  parameter int unsigned TICKS_PER_STEP = rsns_pkg::TICKS_PER_STEP_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire rsns_pkg::in_item_t                  in_item_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output rsns_pkg::out_item_t                      out_item_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [rsns_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [rsns_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned IdxW  = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int unsigned DsrW  = rsns_pkg::DSR_W;
  localparam int unsigned DvdW  = rsns_pkg::DVD_W;
  localparam int unsigned StW   = rsns_pkg::STEP_W;
  localparam logic [DsrW-1:0] DepthW = DsrW'(SEQ_DEPTH);
  localparam logic [DsrW-1:0] TpsW   = DsrW'(TICKS_PER_STEP);
  localparam logic [StW-1:0]  StFull = StW'(DvdW / rsns_pkg::DIV_CHUNK);
  localparam logic [StW-1:0]  St12   = StW'(3);
  localparam logic [StW-1:0]  St16   = StW'(4);

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DIV_T   = 4'd1;
  localparam logic [3:0] ST_DIV_IDX = 4'd2;
  localparam logic [3:0] ST_RD      = 4'd3;
  localparam logic [3:0] ST_CHK     = 4'd4;
  localparam logic [3:0] ST_DIV_LO  = 4'd5;
  localparam logic [3:0] ST_DIV_HI  = 4'd6;
  localparam logic [3:0] ST_DIV_W   = 4'd7;
  localparam logic [3:0] ST_DIV_R   = 4'd8;
  localparam logic [3:0] ST_OUT     = 4'd9;

  // configuration registers
  logic [6:0] low_note_q;
  logic [7:0] high_note_q;
  logic [3:0] tonic_q;
  logic [1:0] scale_sel_q;
  logic [4:0] seq_len_q;
  logic       frozen_q;
  logic [7:0] gate_len_q;
  logic [4:0] midi_ch_q;

  // sequencer state
  logic [3:0]      state_q, state_d;
  logic [31:0]     tick_q, tick_d;
  logic [15:0]     word_q, word_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [DsrW-1:0] a_q, a_d;
  logic [31:0]     start_tick_q, start_tick_d;
  logic [7:0]      last_pitch_q, last_pitch_d;
  logic [4:0]      held_ch_q, held_ch_d;
  rsns_pkg::out_item_t res_q, res_d;
  logic                out_valid_q, out_valid_d;
  rsns_pkg::out_item_t out_q, out_d;
  logic [SEQ_DEPTH-1:0] seq_vld_q;
  logic                 vld_rd_q;

  rsns_pkg::div_req_t div_req;
  rsns_pkg::div_rsp_t div_rsp;

  logic            ram_we;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  logic            enabled;
  logic [DsrW-1:0] len_w;
  logic [3:0]      sz;
  logic [DsrW-1:0] n_lo, n_hi;
  logic [DsrW-1:0] nb_calc;
  logic [DsrW-1:0] rank;
  logic [11:0]     rank_pitch;
  logic [7:0]      note;
  logic [7:0]      replay;
  logic            stop_hit;

  // shared divider
  rsns_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // step note store
  rsns_ram #(
    .WIDTH (8),
    .DEPTH (SEQ_DEPTH)
  ) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_note_q  <= 7'd36;
      high_note_q <= 8'd60;
      tonic_q     <= 4'd0;
      scale_sel_q <= 2'd0;
      seq_len_q   <= 5'd0;
      frozen_q    <= 1'b0;
      gate_len_q  <= 8'd3;
      midi_ch_q   <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsns_pkg::CFG_LOW_NOTE:     low_note_q  <= cfg_data_i[6:0];
        rsns_pkg::CFG_HIGH_NOTE:    high_note_q <= cfg_data_i;
        rsns_pkg::CFG_TONIC:        tonic_q     <= cfg_data_i[3:0];
        rsns_pkg::CFG_SCALE_SELECT: scale_sel_q <= cfg_data_i[1:0];
        rsns_pkg::CFG_SEQ_LENGTH:   seq_len_q   <= cfg_data_i[4:0];
        rsns_pkg::CFG_FROZEN:       frozen_q    <= cfg_data_i[0];
        rsns_pkg::CFG_GATE_LENGTH:  gate_len_q  <= cfg_data_i;
        rsns_pkg::CFG_MIDI_CHANNEL: midi_ch_q   <= cfg_data_i[4:0];
      endcase
    end
  end

  // derived operands
  assign enabled  = (seq_len_q != 5'd0) && (high_note_q > {1'b0, low_note_q});
  assign len_w    = ({4'b0, seq_len_q} > DepthW) ? DepthW : {4'b0, seq_len_q};
  assign sz       = rsns_pkg::SCALE_SIZE[scale_sel_q];
  assign n_lo     = {2'b0, low_note_q} + rsns_pkg::OCT_BIAS - {5'b0, tonic_q};
  assign n_hi     = {1'b0, high_note_q} + rsns_pkg::OCT_BIAS - {5'b0, tonic_q};
  assign stop_hit = (tick_q == start_tick_q + {24'b0, gate_len_q});
  assign replay   = vld_rd_q ? ram_rdata : 8'd0;

  // scale notes below a pitch: whole octaves times size plus partial octave
  assign nb_calc = ({5'b0, sz} * {4'b0, div_rsp.quot[4:0]})
                 + {5'b0, rsns_pkg::below_cnt(scale_sel_q, div_rsp.rem[3:0])};
  assign rank    = a_q + div_rsp.rem;

  // pitch of a rank, transposed and wrapped to eight bits
  assign rank_pitch = (12'(div_rsp.quot[DsrW-1:0]) * 12'(rsns_pkg::OCTAVE))
                    + {8'b0, rsns_pkg::scale_deg(scale_sel_q, div_rsp.rem[3:0])};
  assign note       = 8'(rank_pitch + {8'b0, tonic_q} - {3'b0, rsns_pkg::OCT_BIAS});

  // sequencer
  always_comb begin
    state_d          = state_q;
    tick_d           = tick_q;
    word_d           = word_q;
    idx_d            = idx_q;
    a_d              = a_q;
    start_tick_d     = start_tick_q;
    last_pitch_d     = last_pitch_q;
    held_ch_d        = held_ch_q;
    res_d            = res_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    div_req.steps    = '0;
    ram_we           = 1'b0;
    ram_wdata        = note;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && enabled) begin
          tick_d           = in_item_i.tick_count;
          word_d           = in_item_i.random_word;
          div_req.start    = 1'b1;
          div_req.dividend = in_item_i.tick_count;
          div_req.divisor  = TpsW;
          div_req.steps    = StFull;
          state_d          = ST_DIV_T;
        end
      end
      ST_DIV_T: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quot;
            div_req.divisor  = len_w;
            div_req.steps    = StFull;
            state_d          = ST_DIV_IDX;
          end else if (stop_hit && (last_pitch_q != rsns_pkg::NO_NOTE)) begin
            res_d.is_start    = 1'b0;
            res_d.pitch       = rsns_pkg::sat_pitch(last_pitch_q);
            res_d.channel_out = held_ch_q;
            state_d           = ST_OUT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIV_IDX: begin
        if (div_rsp.done) begin
          idx_d        = div_rsp.rem[IdxW-1:0];
          start_tick_d = tick_q;
          if (frozen_q) begin
            state_d = ST_RD;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = {3'b0, n_lo, 20'b0};
            div_req.divisor  = rsns_pkg::OCTAVE;
            div_req.steps    = St12;
            state_d          = ST_DIV_LO;
          end
        end
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if ((replay >= {1'b0, low_note_q}) && (replay < high_note_q)) begin
          last_pitch_d      = replay;
          held_ch_d         = midi_ch_q;
          res_d.is_start    = 1'b1;
          res_d.pitch       = rsns_pkg::sat_pitch(replay);
          res_d.channel_out = midi_ch_q;
          state_d           = ST_OUT;
        end else begin
          last_pitch_d = rsns_pkg::NO_NOTE;
          state_d      = ST_IDLE;
        end
      end
      ST_DIV_LO: begin
        if (div_rsp.done) begin
          a_d              = nb_calc;
          div_req.start    = 1'b1;
          div_req.dividend = {3'b0, n_hi, 20'b0};
          div_req.divisor  = rsns_pkg::OCTAVE;
          div_req.steps    = St12;
          state_d          = ST_DIV_HI;
        end
      end
      ST_DIV_HI: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          if (nb_calc > a_q) begin
            div_req.dividend = {word_q, 16'b0};
            div_req.divisor  = nb_calc - a_q;
            div_req.steps    = St16;
            state_d          = ST_DIV_W;
          end else begin
            div_req.dividend = {3'b0, a_q, 20'b0};
            div_req.divisor  = {5'b0, sz};
            div_req.steps    = St12;
            state_d          = ST_DIV_R;
          end
        end
      end
      ST_DIV_W: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {3'b0, rank, 20'b0};
          div_req.divisor  = {5'b0, sz};
          div_req.steps    = St12;
          state_d          = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        if (div_rsp.done) begin
          ram_we            = 1'b1;
          last_pitch_d      = note;
          held_ch_d         = midi_ch_q;
          res_d.is_start    = 1'b1;
          res_d.pitch       = rsns_pkg::sat_pitch(note);
          res_d.channel_out = midi_ch_q;
          state_d           = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if ((state_q == ST_OUT) && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      last_pitch_q <= rsns_pkg::NO_NOTE;
      start_tick_q <= '0;
      held_ch_q    <= '0;
      seq_vld_q    <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      last_pitch_q <= last_pitch_d;
      start_tick_q <= start_tick_d;
      held_ch_q    <= held_ch_d;
      if (ram_we) begin
        seq_vld_q[idx_q] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tick_q   <= tick_d;
    word_q   <= word_d;
    idx_q    <= idx_d;
    a_q      <= a_d;
    res_q    <= res_d;
    out_q    <= out_d;
    vld_rd_q <= seq_vld_q[idx_q];
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a result only appears after the sequencer hands one over
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result appeared without sequencer handoff");

  // divider completes only while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_T || state_q == ST_DIV_IDX ||
                      state_q == ST_DIV_LO || state_q == ST_DIV_HI ||
                      state_q == ST_DIV_W || state_q == ST_DIV_R))
    else $error("divider finished with no pending operation");

  // replay mode never overwrites stored notes
  a_frozen_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !frozen_q)
    else $error("step store written in frozen mode");

  // a note start always records the sounding pitch
  a_start_sets_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && $changed(state_q) && res_q.is_start) |->
      (res_q.pitch == rsns_pkg::sat_pitch(last_pitch_q)))
    else $error("note start pitch differs from held pitch");

endmodule

`default_nettype wire
